[rtl/lvsm_pkg.sv]
// Shared types and constants for the local variance soft mask block.
// Holds the configuration record, controller command and status records,
// register indexes and fixed-point constants. No dependencies.
package lvsm_pkg;

	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X       = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y       = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z       = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_RADIUS   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_LO = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_HI = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_LO  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_HI  = 4'd7;

	// divider operand and destination codes
	localparam logic [1:0] DIV_MEAN = 2'd0;
	localparam logic [1:0] DIV_VAR  = 2'd1;
	localparam logic [1:0] DIV_T    = 2'd2;

	localparam logic [16:0] ONE_Q16   = 17'h10000;
	localparam logic [17:0] THREE_Q16 = 18'd196608;

	// signed window coordinate widths: 8 or 16 bit position plus radius
	localparam int CX_W = 11;
	localparam int CZ_W = 19;

	typedef struct packed {
		logic [7:0]  size_x;
		logic [7:0]  size_y;
		logic [15:0] size_z;
		logic [1:0]  box_radius;
		logic [15:0] intensity_lo;
		logic [15:0] intensity_hi;
		logic [30:0] variance_lo;
		logic [30:0] variance_hi;
	} lvsm_cfg_t;

	typedef struct packed {
		logic       capture;
		logic       step;
		logic       win_init;
		logic       win_step;
		logic       mul;
		logic       diff;
		logic       div_start;
		logic [1:0] div_op;
		logic       div_load;
		logic [1:0] div_dst;
		logic       ss_sel;
		logic       hard_load;
		logic       t_clamp;
		logic       sq;
		logic       poly;
		logic       emit;
	} lvsm_cmd_t;

	typedef struct packed {
		logic emit_ok;
		logic win_last;
		logic div_busy;
		logic div_done;
		logic ss_hard;
		logic ss_need_div;
		logic out_free;
	} lvsm_sts_t;

endpackage

[rtl/local_variance_soft_mask_3d.sv]
// Top level of the local variance soft mask: configuration registers,
// controller and datapath. Uses lvsm_pkg, lvsm_ctrl and lvsm_datapath.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata voxel_value, tuser kind
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata mask_value, tlast is_last
//  cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One item at a time. An item that yields a result is swept one window
// position per cycle through the single read port of the voxel ring, then goes
// through up to four bit-serial divisions (mean, variance and, where needed,
// two smoothstep ratios).
// Reset clears the stream counters and control; the ring needs no clearing.
// A finished result waits in the output register while the next item is taken;
// the next result holds in the datapath until that register is free.
module local_variance_soft_mask_3d #(
	parameter int MAX_SIZE_X = 128,
	parameter int MAX_SIZE_Y = 128,
	parameter int MAX_RADIUS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] voxel_value
	input  logic [0:0]  s_axis_tuser,   // [0] kind: 0 voxel, 1 drain
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] mask_value
	output logic        m_axis_tlast,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lvsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lvsm_pkg::CFG_DAT_W-1:0]    cfg_data
);

	import lvsm_pkg::*;

	lvsm_cfg_t cfg_q;
	lvsm_cmd_t cmd;
	lvsm_sts_t sts;

	// config is always taken; unknown indexes drop the write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size_x       <= 8'd128;
			cfg_q.size_y       <= 8'd128;
			cfg_q.size_z       <= 16'd1;
			cfg_q.box_radius   <= 2'd1;
			cfg_q.intensity_lo <= 16'd0;
			cfg_q.intensity_hi <= 16'hFFFF;
			cfg_q.variance_lo  <= 31'd0;
			cfg_q.variance_hi  <= 31'd1073741824;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SIZE_X:       cfg_q.size_x       <= cfg_data[7:0];
				REG_SIZE_Y:       cfg_q.size_y       <= cfg_data[7:0];
				REG_SIZE_Z:       cfg_q.size_z       <= cfg_data[15:0];
				REG_BOX_RADIUS:   cfg_q.box_radius   <= cfg_data[1:0];
				REG_INTENSITY_LO: cfg_q.intensity_lo <= cfg_data[15:0];
				REG_INTENSITY_HI: cfg_q.intensity_hi <= cfg_data[15:0];
				REG_VARIANCE_LO:  cfg_q.variance_lo  <= cfg_data[30:0];
				REG_VARIANCE_HI:  cfg_q.variance_hi  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// sequencer: accepts an item only when idle
	lvsm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// ring, window statistics, divisions and the output register
	lvsm_datapath #(
		.MAX_SIZE_X(MAX_SIZE_X),
		.MAX_SIZE_Y(MAX_SIZE_Y),
		.MAX_RADIUS(MAX_RADIUS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.sts      (sts),
		.in_kind  (s_axis_tuser[0]),
		.in_value (s_axis_tdata),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_mask (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

endmodule

[rtl/lvsm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lvsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/lvsm_div.sv]
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module lvsm_div #(
	parameter int DVD_W = 48,
	parameter int DVS_W = 31
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int C_W = $clog2(DVD_W);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [C_W-1:0]   cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= C_W'(DVD_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign busy     = run_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/lvsm_datapath.sv]
// Datapath: voxel ring memory, window sweep, moment accumulators, shared
// divider, smoothstep arithmetic and the output register. Uses lvsm_pkg,
// lvsm_ram and lvsm_div.
module lvsm_datapath #(
	parameter int MAX_SIZE_X = 128,
	parameter int MAX_SIZE_Y = 128,
	parameter int MAX_RADIUS = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lvsm_pkg::lvsm_cfg_t cfg,
	input  lvsm_pkg::lvsm_cmd_t cmd,
	output lvsm_pkg::lvsm_sts_t sts,
	input  logic               in_kind,
	input  logic [15:0]        in_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        out_mask,
	output logic               out_last
);

	import lvsm_pkg::*;

	localparam int LAG_MAX   = MAX_RADIUS * (MAX_SIZE_X * MAX_SIZE_Y + MAX_SIZE_X + 1);
	localparam int AW        = $clog2(2 * LAG_MAX + 1);
	localparam int DEPTH     = 1 << AW;
	localparam int CNT_W     = $clog2(longint'(MAX_SIZE_X) * MAX_SIZE_Y * 65535 + 1);
	localparam int LAG_W     = $clog2(LAG_MAX + 1);
	localparam int CMP_W     = ((CNT_W > LAG_W) ? CNT_W : LAG_W) + 1;
	localparam int PL_W      = $clog2(MAX_SIZE_X * MAX_SIZE_Y + 1);
	localparam int CW        = $clog2((2 * MAX_RADIUS + 1) ** 3 + 1);
	localparam int SUM_W     = 16 + CW;
	localparam int SUM2_W    = 32 + CW;
	localparam int A_W       = SUM2_W + CW;
	localparam int B_W       = 2 * SUM_W;
	localparam int P_W       = (A_W > B_W) ? A_W : B_W;
	localparam int DVD_W     = (P_W > 47) ? P_W : 47;
	localparam int DVS_W     = (2 * CW > 31) ? 2 * CW : 31;

	// clamped geometry
	logic [7:0]  sx_c, sy_c;
	logic [15:0] sz_c;
	logic [1:0]  r_c;

	always_comb begin
		sx_c = cfg.size_x;
		if (cfg.size_x == 8'd0) begin
			sx_c = 8'd1;
		end else if (int'(cfg.size_x) > MAX_SIZE_X) begin
			sx_c = 8'(MAX_SIZE_X);
		end
		sy_c = cfg.size_y;
		if (cfg.size_y == 8'd0) begin
			sy_c = 8'd1;
		end else if (int'(cfg.size_y) > MAX_SIZE_Y) begin
			sy_c = 8'(MAX_SIZE_Y);
		end
		sz_c = (cfg.size_z == 16'd0) ? 16'd1 : cfg.size_z;
		r_c = cfg.box_radius;
		if (cfg.box_radius == 2'd0) begin
			r_c = 2'd1;
		end else if (int'(cfg.box_radius) > MAX_RADIUS) begin
			r_c = 2'(MAX_RADIUS);
		end
	end

	logic [7:0]       sx_q, sy_q;
	logic [15:0]      sz_q;
	logic [1:0]       r_q;
	logic [PL_W-1:0]  plane_q;
	logic [CNT_W-1:0] total_q;
	logic [LAG_W-1:0] lag_q;

	always_ff @(posedge clk) begin
		sx_q    <= sx_c;
		sy_q    <= sy_c;
		sz_q    <= sz_c;
		r_q     <= r_c;
		plane_q <= PL_W'(16'(sx_c) * 16'(sy_c));
		total_q <= CNT_W'(32'(plane_q) * 32'(sz_q));
		lag_q   <= LAG_W'(32'(r_q) * (32'(plane_q) + 32'(sx_q) + 32'd1));
	end

	// captured item
	logic        kind_q;
	logic [15:0] value_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= in_kind;
			value_q <= in_value;
		end
	end

	// stream counters and the output voxel position
	logic [CNT_W-1:0] in_cnt_q, out_cnt_q;
	logic [7:0]       ox_q, oy_q;
	logic [15:0]      oz_q;
	logic             wrap;
	logic [CNT_W-1:0] in_eff;
	logic             wr_en;
	logic             is_last;

	assign wrap    = out_cnt_q >= total_q;
	assign in_eff  = wrap ? '0 : in_cnt_q;
	assign wr_en   = cmd.step && !kind_q && (in_eff < total_q);
	assign is_last = ((CNT_W+1)'(out_cnt_q) + 1'b1) == (CNT_W+1)'(total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
			ox_q      <= '0;
			oy_q      <= '0;
			oz_q      <= '0;
		end else if (cmd.step) begin
			in_cnt_q <= in_eff + CNT_W'(wr_en);
			if (wrap) begin
				out_cnt_q <= '0;
				ox_q      <= '0;
				oy_q      <= '0;
				oz_q      <= '0;
			end
		end else if (cmd.emit) begin
			if (is_last) begin
				in_cnt_q  <= '0;
				out_cnt_q <= '0;
				ox_q      <= '0;
				oy_q      <= '0;
				oz_q      <= '0;
			end else begin
				out_cnt_q <= out_cnt_q + 1'b1;
				if (ox_q == sx_q - 8'd1) begin
					ox_q <= '0;
					if (oy_q == sy_q - 8'd1) begin
						oy_q <= '0;
						oz_q <= oz_q + 16'd1;
					end else begin
						oy_q <= oy_q + 8'd1;
					end
				end else begin
					ox_q <= ox_q + 8'd1;
				end
			end
		end
	end

	assign sts.emit_ok = (CMP_W'(in_cnt_q) >= CMP_W'(total_q)) ||
		(CMP_W'(in_cnt_q) > CMP_W'(out_cnt_q) + CMP_W'(lag_q));

	// window sweep
	logic signed [CX_W-1:0] cx_q, cy_q, xend_q, yend_q, xbeg_q, ybeg_q;
	logic signed [CZ_W-1:0] cz_q, zend_q;
	logic [AW-1:0]          addr_q, row_addr_q, plane_addr_q;
	logic [AW-1:0]          base, row_next, plane_next;
	logic                   inrange;
	logic signed [CX_W-1:0] r_x;
	logic signed [CZ_W-1:0] r_z;

	assign r_x        = $signed(CX_W'(r_q));
	assign r_z        = $signed(CZ_W'(r_q));
	assign base       = out_cnt_q[AW-1:0] - AW'(lag_q);
	assign row_next   = row_addr_q + AW'(sx_q);
	assign plane_next = plane_addr_q + AW'(plane_q);
	assign inrange    = !cx_q[CX_W-1] && (cx_q < $signed({3'b0, sx_q})) &&
		!cy_q[CX_W-1] && (cy_q < $signed({3'b0, sy_q})) &&
		!cz_q[CZ_W-1] && (cz_q < $signed({3'b0, sz_q}));
	assign sts.win_last = (cx_q == xend_q) && (cy_q == yend_q) && (cz_q == zend_q);

	always_ff @(posedge clk) begin
		if (cmd.win_init) begin
			xbeg_q       <= $signed({3'b0, ox_q}) - r_x;
			ybeg_q       <= $signed({3'b0, oy_q}) - r_x;
			cx_q         <= $signed({3'b0, ox_q}) - r_x;
			cy_q         <= $signed({3'b0, oy_q}) - r_x;
			cz_q         <= $signed({3'b0, oz_q}) - r_z;
			xend_q       <= $signed({3'b0, ox_q}) + r_x;
			yend_q       <= $signed({3'b0, oy_q}) + r_x;
			zend_q       <= $signed({3'b0, oz_q}) + r_z;
			addr_q       <= base;
			row_addr_q   <= base;
			plane_addr_q <= base;
		end else if (cmd.win_step) begin
			if (cx_q != xend_q) begin
				cx_q   <= cx_q + 1'b1;
				addr_q <= addr_q + 1'b1;
			end else if (cy_q != yend_q) begin
				cx_q       <= xbeg_q;
				cy_q       <= cy_q + 1'b1;
				row_addr_q <= row_next;
				addr_q     <= row_next;
			end else begin
				cx_q         <= xbeg_q;
				cy_q         <= ybeg_q;
				cz_q         <= cz_q + 1'b1;
				plane_addr_q <= plane_next;
				row_addr_q   <= plane_next;
				addr_q       <= plane_next;
			end
		end
	end

	logic [15:0] rdata;

	lvsm_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (wr_en),
		.waddr(in_eff[AW-1:0]),
		.wdata(value_q),
		.raddr(addr_q),
		.rdata(rdata)
	);

	// read, square, accumulate
	logic              valid_s1, valid_s2;
	logic [15:0]       val_s2;
	logic [31:0]       sq_s2;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM2_W-1:0] sum2_q;
	logic [CW-1:0]     cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.win_step && inrange;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		val_s2 <= rdata;
		sq_s2  <= 32'(rdata) * 32'(rdata);
		if (cmd.win_init) begin
			sum_q  <= '0;
			sum2_q <= '0;
			cnt_q  <= '0;
		end else if (valid_s2) begin
			sum_q  <= sum_q + SUM_W'(val_s2);
			sum2_q <= sum2_q + SUM2_W'(sq_s2);
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	// variance numerator cnt*sum2 - sum^2, and cnt^2
	logic [P_W-1:0]  prod_a_q, prod_b_q, num_q;
	logic [2*CW-1:0] cnt2_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_a_q <= P_W'(sum2_q) * P_W'(cnt_q);
			prod_b_q <= P_W'(sum_q) * P_W'(sum_q);
		end
		if (cmd.diff) begin
			num_q  <= (prod_a_q > prod_b_q) ? prod_a_q - prod_b_q : '0;
			cnt2_q <= (2*CW)'(cnt_q) * (2*CW)'(cnt_q);
		end
	end

	// smoothstep operands
	logic [31:0] ss_x, ss_lo, ss_hi;

	assign ss_x  = cmd.ss_sel ? var_q : 32'(mean_q);
	assign ss_lo = cmd.ss_sel ? 32'(cfg.variance_lo) : 32'(cfg.intensity_lo);
	assign ss_hi = cmd.ss_sel ? 32'(cfg.variance_hi) : 32'(cfg.intensity_hi);
	assign sts.ss_hard     = ss_hi <= ss_lo;
	assign sts.ss_need_div = (ss_x > ss_lo) && (ss_x < ss_hi);

	// shared divider
	logic [DVD_W-1:0] dvd, quo;
	logic [DVS_W-1:0] dvs;
	logic [15:0]      mean_q;
	logic [31:0]      var_q;
	logic [47:0]      t_num;

	assign t_num = {ss_x - ss_lo, 16'd0};

	always_comb begin
		unique case (cmd.div_op)
			DIV_MEAN: begin
				dvd = DVD_W'(sum_q);
				dvs = DVS_W'(cnt_q);
			end
			DIV_VAR: begin
				dvd = DVD_W'(num_q);
				dvs = DVS_W'(cnt2_q);
			end
			default: begin
				dvd = DVD_W'(t_num);
				dvs = DVS_W'(ss_hi - ss_lo);
			end
		endcase
	end

	lvsm_div #(
		.DVD_W(DVD_W),
		.DVS_W(DVS_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(dvd),
		.divisor (dvs),
		.busy    (sts.div_busy),
		.done    (sts.div_done),
		.quotient(quo)
	);

	// smoothstep t*t*(3-2t) and mask product
	logic [16:0] t_q, term_m_q, term_v_q, hard_term, poly_term;
	logic [33:0] t2_q;
	logic [17:0] polyv;
	logic [51:0] poly_prod;
	logic [33:0] mask_prod;
	logic [17:0] mask_shift;

	assign hard_term  = (ss_x >= ss_hi) ? ONE_Q16 : 17'd0;
	assign polyv      = THREE_Q16 - {t_q, 1'b0};
	assign poly_prod  = 52'(t2_q) * 52'(polyv);
	assign poly_term  = poly_prod[48:32];
	assign mask_prod  = 34'(term_m_q) * 34'(term_v_q);
	assign mask_shift = mask_prod[33:16];

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			case (cmd.div_dst)
				DIV_MEAN: mean_q <= quo[15:0];
				DIV_VAR:  var_q  <= quo[31:0];
				default:  t_q    <= quo[16:0];
			endcase
		end
		if (cmd.t_clamp) begin
			t_q <= (ss_x <= ss_lo) ? 17'd0 : ONE_Q16;
		end
		if (cmd.sq) begin
			t2_q <= 34'(t_q) * 34'(t_q);
		end
		if (cmd.hard_load || cmd.poly) begin
			if (cmd.ss_sel) begin
				term_v_q <= cmd.hard_load ? hard_term : poly_term;
			end else begin
				term_m_q <= cmd.hard_load ? hard_term : poly_term;
			end
		end
	end

	// output register
	logic        out_valid_q;
	logic [15:0] mask_q;
	logic        last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			mask_q <= (mask_shift[17:16] != 2'd0) ? 16'hFFFF : mask_shift[15:0];
			last_q <= is_last;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_mask     = mask_q;
	assign out_last     = last_q;

endmodule

[rtl/lvsm_ctrl.sv]
// Controller state machine: sequences each item through the datapath.
// Uses lvsm_pkg command and status records.
module lvsm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lvsm_pkg::lvsm_sts_t sts,
	output lvsm_pkg::lvsm_cmd_t cmd
);

	import lvsm_pkg::*;

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_GEO1    = 5'd1;
	localparam logic [4:0] ST_GEO2    = 5'd2;
	localparam logic [4:0] ST_STEP    = 5'd3;
	localparam logic [4:0] ST_DECIDE  = 5'd4;
	localparam logic [4:0] ST_SWEEP   = 5'd5;
	localparam logic [4:0] ST_FLUSH1  = 5'd6;
	localparam logic [4:0] ST_FLUSH2  = 5'd7;
	localparam logic [4:0] ST_MULT    = 5'd8;
	localparam logic [4:0] ST_DIFF    = 5'd9;
	localparam logic [4:0] ST_DIVM    = 5'd10;
	localparam logic [4:0] ST_DIVV    = 5'd11;
	localparam logic [4:0] ST_SS_PREP = 5'd12;
	localparam logic [4:0] ST_SS_DIV  = 5'd13;
	localparam logic [4:0] ST_SS_SQ   = 5'd14;
	localparam logic [4:0] ST_SS_POLY = 5'd15;
	localparam logic [4:0] ST_EMIT    = 5'd16;

	logic [4:0] state_q, state_d;
	logic       sel_q, sel_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		sel_d    = sel_q;
		in_ready = 1'b0;
		cmd.ss_sel = sel_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_GEO1;
				end
			end
			ST_GEO1: state_d = ST_GEO2;
			ST_GEO2: state_d = ST_STEP;
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d  = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.emit_ok) begin
					cmd.win_init = 1'b1;
					sel_d        = 1'b0;
					state_d      = ST_SWEEP;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				cmd.win_step = 1'b1;
				if (sts.win_last) begin
					state_d = ST_FLUSH1;
				end
			end
			ST_FLUSH1: state_d = ST_FLUSH2;
			ST_FLUSH2: state_d = ST_MULT;
			ST_MULT: begin
				cmd.mul = 1'b1;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff      = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_op    = DIV_MEAN;
				state_d       = ST_DIVM;
			end
			ST_DIVM: begin
				if (sts.div_done) begin
					cmd.div_load  = 1'b1;
					cmd.div_dst   = DIV_MEAN;
					cmd.div_start = 1'b1;
					cmd.div_op    = DIV_VAR;
					state_d       = ST_DIVV;
				end
			end
			ST_DIVV: begin
				if (sts.div_done) begin
					cmd.div_load = 1'b1;
					cmd.div_dst  = DIV_VAR;
					state_d      = ST_SS_PREP;
				end
			end
			ST_SS_PREP: begin
				if (sts.ss_hard) begin
					cmd.hard_load = 1'b1;
					if (sel_q) begin
						state_d = ST_EMIT;
					end else begin
						sel_d = 1'b1;
					end
				end else if (sts.ss_need_div) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = DIV_T;
					state_d       = ST_SS_DIV;
				end else begin
					cmd.t_clamp = 1'b1;
					state_d     = ST_SS_SQ;
				end
			end
			ST_SS_DIV: begin
				if (sts.div_done) begin
					cmd.div_load = 1'b1;
					cmd.div_dst  = DIV_T;
					state_d      = ST_SS_SQ;
				end
			end
			ST_SS_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_SS_POLY;
			end
			ST_SS_POLY: begin
				cmd.poly = 1'b1;
				if (sel_q) begin
					state_d = ST_EMIT;
				end else begin
					sel_d   = 1'b1;
					state_d = ST_SS_PREP;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded while output register still full");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider restarted while busy");

	a_div_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |-> sts.div_done)
		else $error("quotient taken before divider finished");

	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.win_step && sts.win_last |=> !cmd.win_step)
		else $error("window sweep ran past its last position");

endmodule
